// ===== rtl/core/wfpa_pkg.sv =====
// shared widths, command codes and types for the worst-fit partition allocator
package wfpa_pkg;

	localparam int CFG_W     = 5;
	localparam int SLOT_W    = 4;
	localparam int AMOUNT_W  = 16;
	localparam int CHOSEN_W  = 4;
	localparam int WASTE_W   = 16;
	localparam int TOTAL_W   = 32;
	localparam int S_TDATA_W = 24;
	localparam int M_TDATA_W = 56;

	localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_ALLOC = 1'b1;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_SCAN   = 5'b00010,
		ST_DRAIN  = 5'b00100,
		ST_DECIDE = 5'b01000,
		ST_RESULT = 5'b10000
	} state_t;

	typedef struct packed {
		logic clear;
		logic valid;
	} scan_ctl_t;

endpackage

// ===== rtl/core/wfpa_ram.sv =====
// partition size table: one write port, one read port with registered data
module wfpa_ram #(
	parameter int DEPTH  = 16,
	parameter int ADDR_W = 4,
	parameter int DATA_W = 16
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/wfpa_scan.sv =====
// running worst-fit tracker: keeps the largest entry that still covers the request
module wfpa_scan #(
	parameter int IDX_W  = 4,
	parameter int SIZE_W = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  wfpa_pkg::scan_ctl_t  ctl,
	input  logic [IDX_W-1:0]     idx,
	input  logic [SIZE_W-1:0]    rd_data,
	input  logic [SIZE_W-1:0]    amount,
	output logic                 found,
	output logic [IDX_W-1:0]     best_idx,
	output logic [SIZE_W-1:0]    best_val
);

	import wfpa_pkg::*;

	logic              found_q;
	logic [IDX_W-1:0]  best_idx_q;
	logic [SIZE_W-1:0] best_val_q;
	logic              hit;

	// strict compare keeps the lowest index on ties
	assign hit = ctl.valid && (amount <= rd_data) && (!found_q || (best_val_q < rd_data));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (ctl.clear) begin
			found_q <= 1'b0;
		end else if (hit) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (hit && !ctl.clear) begin
			best_idx_q <= idx;
			best_val_q <= rd_data;
		end
	end

	assign found    = found_q;
	assign best_idx = best_idx_q;
	assign best_val = best_val_q;

endmodule

// ===== rtl/core/worst_fit_partition_allocator.sv =====
// worst-fit partition allocator top: sequencer, waste total and output register
// load word: written to the table in the accept cycle; the acknowledgement then passes through the result state
// allocate word: accept, then N table reads in the scan state, N = min(partitions_in_use, MAX_PARTITIONS),
// then drain, decide and result (no scan or drain when N is 0); one table read per cycle, one word in flight
// a finished result waits in the output register while the next word is taken
// reset clears control, waste total and sets partitions_in_use to 16; table is not cleared
module worst_fit_partition_allocator #(
	parameter int MAX_PARTITIONS = 16,
	parameter int SIZE_BITS      = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [wfpa_pkg::CFG_W-1:0]    cfg_data,     // partitions_in_use
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [wfpa_pkg::S_TDATA_W-1:0] s_tdata,     // slot[3:0], amount[19:4]
	input  logic                          s_tuser,      // cmd
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [wfpa_pkg::M_TDATA_W-1:0] m_tdata,     // chosen_partition[3:0], waste[19:4],
	                                                    // total_waste[51:20]
	output logic                          m_tuser       // granted
);

	import wfpa_pkg::*;

	localparam int IDX_W = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;

	state_t               state_q;
	logic [CFG_W-1:0]     cfg_q;
	logic [CFG_W-1:0]     n_q;
	logic [CFG_W-1:0]     cnt_q;
	logic [CFG_W-1:0]     scan_n;
	logic [SIZE_BITS-1:0] amount_q;
	logic [TOTAL_W-1:0]   waste_sum_q;

	logic                 rd_valid_s1;
	logic [IDX_W-1:0]     rd_idx_s1;

	logic                 res_granted_q;
	logic [CHOSEN_W-1:0]  res_idx_q;
	logic [WASTE_W-1:0]   res_waste_q;
	logic [TOTAL_W-1:0]   res_total_q;

	logic                 m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;
	logic                 m_tuser_q;

	logic [SLOT_W-1:0]    in_slot;
	logic [AMOUNT_W-1:0]  in_amount;
	logic                 in_accept;
	logic                 slot_ok;
	logic                 out_free;

	logic                 ram_we;
	logic [IDX_W-1:0]     ram_waddr;
	logic [SIZE_BITS-1:0] ram_wdata;
	logic [SIZE_BITS-1:0] ram_rdata;

	scan_ctl_t            scan_ctl;
	logic                 found;
	logic [IDX_W-1:0]     best_idx;
	logic [SIZE_BITS-1:0] best_val;
	logic [SIZE_BITS-1:0] left;
	logic [TOTAL_W:0]     sum_wide;
	logic [TOTAL_W-1:0]   sum_sat;

	assign in_slot   = s_tdata[SLOT_W-1:0];
	assign in_amount = s_tdata[SLOT_W+AMOUNT_W-1:SLOT_W];
	assign s_tready  = (state_q == ST_IDLE);
	assign in_accept = s_tvalid && s_tready;
	assign slot_ok   = ({{(32-SLOT_W){1'b0}}, in_slot} < 32'(MAX_PARTITIONS));
	assign out_free  = !m_tvalid_q || m_tready;
	assign cfg_ready = 1'b1;

	// scan count saturates at the table depth
	assign scan_n = ({{(32-CFG_W){1'b0}}, cfg_q} > 32'(MAX_PARTITIONS)) ?
		CFG_W'(MAX_PARTITIONS) : cfg_q;

	assign left     = best_val - amount_q;
	assign sum_wide = {1'b0, waste_sum_q} + (TOTAL_W+1)'(left);
	assign sum_sat  = sum_wide[TOTAL_W] ? {TOTAL_W{1'b1}} : sum_wide[TOTAL_W-1:0];

	// table writes: load in the accept cycle, or write-back of the chosen entry
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = IDX_W'(in_slot);
		ram_wdata = SIZE_BITS'(in_amount);
		if (in_accept && (s_tuser == CMD_LOAD) && slot_ok) begin
			ram_we = 1'b1;
		end else if ((state_q == ST_DECIDE) && found) begin
			ram_we    = 1'b1;
			ram_waddr = best_idx;
			ram_wdata = left;
		end
	end

	assign scan_ctl.clear = in_accept;
	assign scan_ctl.valid = rd_valid_s1;

	wfpa_ram #(
		.DEPTH  (MAX_PARTITIONS),
		.ADDR_W (IDX_W),
		.DATA_W (SIZE_BITS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (IDX_W'(cnt_q)),
		.rdata (ram_rdata)
	);

	wfpa_scan #(
		.IDX_W  (IDX_W),
		.SIZE_W (SIZE_BITS)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (scan_ctl),
		.idx      (rd_idx_s1),
		.rd_data  (ram_rdata),
		.amount   (amount_q),
		.found    (found),
		.best_idx (best_idx),
		.best_val (best_val)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			cfg_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			n_q         <= '0;
			rd_valid_s1 <= 1'b0;
			waste_sum_q <= '0;
		end else begin
			rd_valid_s1 <= (state_q == ST_SCAN);
			case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						cnt_q <= '0;
						n_q   <= scan_n;
						if (s_tuser == CMD_LOAD) begin
							state_q <= ST_RESULT;
						end else if (scan_n == '0) begin
							state_q <= ST_DECIDE;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == n_q - 1'b1) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					if (found) begin
						waste_sum_q <= sum_sat;
					end
					state_q <= ST_RESULT;
				end
				ST_RESULT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		rd_idx_s1 <= IDX_W'(cnt_q);
		if (in_accept) begin
			amount_q      <= SIZE_BITS'(in_amount);
			res_granted_q <= 1'b0;
			res_idx_q     <= '0;
			res_waste_q   <= '0;
			res_total_q   <= '0;
		end else if (state_q == ST_DECIDE) begin
			res_granted_q <= found;
			res_idx_q     <= found ? CHOSEN_W'(best_idx) : '0;
			res_waste_q   <= found ? WASTE_W'(left) : '0;
			res_total_q   <= found ? sum_sat : waste_sum_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if ((state_q == ST_RESULT) && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_RESULT) && out_free) begin
			m_tdata_q <= M_TDATA_W'({res_total_q, res_waste_q, res_idx_q});
			m_tuser_q <= res_granted_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// the read counter stays inside the scan window
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (cnt_q < n_q))
		else $error("scan counter beyond window");

	// a chosen entry always covers the request
	a_fit: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_DECIDE) && found) |-> (best_val >= amount_q))
		else $error("chosen entry smaller than request");

	// the waste total never decreases
	a_total_mono: assert property (@(posedge clk) disable iff (!arst_n)
		waste_sum_q >= $past(waste_sum_q))
		else $error("waste total decreased");

	// a result that is not granted carries no partition and no waste
	a_no_grant: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tdata[CHOSEN_W+WASTE_W-1:0] == '0))
		else $error("waste reported without grant");

endmodule
